@@ hw/rtl/bary2d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bary2d_pkg
// Shared constants for the 2D barycentric weight pipeline.
// ----------------------------------------------------------------------------
package bary2d_pkg;

    // Default coordinate width (Q12.4) and weight fraction bits (Q15.16).
    localparam int COORD_WIDTH_DEF      = 16;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    // Weights are always 32-bit signed.
    localparam int WEIGHT_WIDTH = 32;

    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_MAX = 32'h7FFF_FFFF;
    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_MIN = 32'h8000_0000;

endpackage

@@ hw/rtl/barycentric_coords_2d.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barycentric_coords_2d
// Barycentric weights of a 2D point against a triangle, fully pipelined.
// ----------------------------------------------------------------------------
// One request in, one result out per clock unless stalled. A request carries the
// point p and the corners a, b, c as signed fixed-point coordinates and returns
// the weights of a, b and c as signed 32-bit values with WEIGHT_FRAC_BITS
// fraction bits, plus a degenerate flag (zero-area triangle, weights forced to
// zero) and a saturated flag (a weight was clipped to the 32-bit range).
// The restoring divider, which spends one pipeline stage per quotient bit, sets
// most of the depth, which grows with COORD_WIDTH and WEIGHT_FRAC_BITS; the
// defaults are Q12.4 / Q15.16. Throughput is one request per cycle unless stalled.
// Every stage has its own valid bit and only holds when the stage after it is
// full and holding, so empty slots close up during an output stall and new
// requests keep entering until the pipeline is truly full.
//
// Stage map:
//   S1  edge vectors ab = b - a, ac = c - a, ap = p - a
//   S2  six signed products
//   S3  determinant and the two numerators (exact width)
//   S4  magnitudes, quotient signs, degenerate detect
//   D0..D(NQ-1)  one restoring-division step per stage, b and c side by side
//   S5  apply quotient signs
//   S6  weight a = 1.0 - wb - wc, clip b and c
//   S7  clip a, output register
// ----------------------------------------------------------------------------
module barycentric_coords_2d
    import bary2d_pkg::*;
#(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [COORD_WIDTH-1:0]  px,
    input  logic signed [COORD_WIDTH-1:0]  py,
    input  logic signed [COORD_WIDTH-1:0]  ax,
    input  logic signed [COORD_WIDTH-1:0]  ay,
    input  logic signed [COORD_WIDTH-1:0]  bx,
    input  logic signed [COORD_WIDTH-1:0]  by_coord,
    input  logic signed [COORD_WIDTH-1:0]  cx,
    input  logic signed [COORD_WIDTH-1:0]  cy,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [WEIGHT_WIDTH-1:0] weight_a,
    output logic signed [WEIGHT_WIDTH-1:0] weight_b,
    output logic signed [WEIGHT_WIDTH-1:0] weight_c,
    output logic                           degenerate,
    output logic                           saturated
);

    // Edge vector width, product width, exact numerator / determinant width.
    localparam int EW = COORD_WIDTH + 1;
    localparam int PW = 2 * EW;
    localparam int DW = PW + 1;
    // Dividend = |num| << F; quotient has as many bits, one stage each.
    localparam int NW = DW + WEIGHT_FRAC_BITS;
    localparam int NQ = NW;
    // Working width for the weight-a sum and the clip check.
    localparam int XW = (NW + 3 > WEIGHT_WIDTH + 1) ? NW + 3 : WEIGHT_WIDTH + 1;
    // Pipeline stages: S1..S4, NQ divide steps, S5..S7.
    localparam int NS = NQ + 7;
    localparam int ST_S4 = 3;
    localparam int ST_S5 = NQ + 4;
    localparam int ST_S6 = NQ + 5;
    localparam int ST_S7 = NQ + 6;

    // ------------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its content moves on.
    // ------------------------------------------------------------------------
    logic          vld_reg [0:NS-1];
    logic [NS-1:0] load;

    assign load[NS-1] = !vld_reg[NS-1] || !out_stall;

    for (genvar s = 0; s < NS - 1; s++) begin : g_load
        assign load[s] = !vld_reg[s] || load[s+1];
    end

    assign in_stall  = !load[0];
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int s = 0; s < NS; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end
        else begin
            if (load[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (load[s]) begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // S1: edge vectors
    // ------------------------------------------------------------------------
    logic signed [EW-1:0] abx_reg, aby_reg, acx_reg, acy_reg, apx_reg, apy_reg;
    logic signed [EW-1:0] abx_next, aby_next, acx_next, acy_next, apx_next, apy_next;

    assign abx_next = {bx[COORD_WIDTH-1], bx} - {ax[COORD_WIDTH-1], ax};
    assign aby_next = {by_coord[COORD_WIDTH-1], by_coord} - {ay[COORD_WIDTH-1], ay};
    assign acx_next = {cx[COORD_WIDTH-1], cx} - {ax[COORD_WIDTH-1], ax};
    assign acy_next = {cy[COORD_WIDTH-1], cy} - {ay[COORD_WIDTH-1], ay};
    assign apx_next = {px[COORD_WIDTH-1], px} - {ax[COORD_WIDTH-1], ax};
    assign apy_next = {py[COORD_WIDTH-1], py} - {ay[COORD_WIDTH-1], ay};

    always_ff @(posedge clk) begin
        if (load[0]) begin
            abx_reg <= abx_next;
            aby_reg <= aby_next;
            acx_reg <= acx_next;
            acy_reg <= acy_next;
            apx_reg <= apx_next;
            apy_reg <= apy_next;
        end
    end

    // ------------------------------------------------------------------------
    // S2: products
    // ------------------------------------------------------------------------
    logic signed [PW-1:0] p_den0_reg, p_den1_reg, p_b0_reg, p_b1_reg, p_c0_reg, p_c1_reg;
    logic signed [PW-1:0] p_den0_next, p_den1_next, p_b0_next, p_b1_next;
    logic signed [PW-1:0] p_c0_next, p_c1_next;

    assign p_den0_next = abx_reg * acy_reg;
    assign p_den1_next = acx_reg * aby_reg;
    assign p_b0_next   = apx_reg * acy_reg;
    assign p_b1_next   = acx_reg * apy_reg;
    assign p_c0_next   = abx_reg * apy_reg;
    assign p_c1_next   = apx_reg * aby_reg;

    always_ff @(posedge clk) begin
        if (load[1]) begin
            p_den0_reg <= p_den0_next;
            p_den1_reg <= p_den1_next;
            p_b0_reg   <= p_b0_next;
            p_b1_reg   <= p_b1_next;
            p_c0_reg   <= p_c0_next;
            p_c1_reg   <= p_c1_next;
        end
    end

    // ------------------------------------------------------------------------
    // S3: determinant and numerators
    // ------------------------------------------------------------------------
    logic signed [DW-1:0] den_reg, num_b_reg, num_c_reg;
    logic signed [DW-1:0] den_next, num_b_next, num_c_next;

    assign den_next   = {p_den0_reg[PW-1], p_den0_reg} - {p_den1_reg[PW-1], p_den1_reg};
    assign num_b_next = {p_b0_reg[PW-1], p_b0_reg} - {p_b1_reg[PW-1], p_b1_reg};
    assign num_c_next = {p_c0_reg[PW-1], p_c0_reg} - {p_c1_reg[PW-1], p_c1_reg};

    always_ff @(posedge clk) begin
        if (load[2]) begin
            den_reg   <= den_next;
            num_b_reg <= num_b_next;
            num_c_reg <= num_c_next;
        end
    end

    // ------------------------------------------------------------------------
    // S4 and divide steps. Index 0 of each array is S4; step k fills k+1.
    // The dividend register shifts out its top bit each step and takes the
    // new quotient bit at the bottom, so it ends up holding the quotient.
    // ------------------------------------------------------------------------
    logic [DW-1:0] dmag_reg  [0:NQ];
    logic [DW-1:0] rem_b_reg [0:NQ];
    logic [DW-1:0] rem_c_reg [0:NQ];
    logic [NW-1:0] dvd_b_reg [0:NQ];
    logic [NW-1:0] dvd_c_reg [0:NQ];
    logic          sgn_b_reg [0:NQ];
    logic          sgn_c_reg [0:NQ];
    logic          degen_reg [0:NQ];

    logic [DW-1:0] dmag_next, mag_b_next, mag_c_next;

    assign dmag_next  = den_reg[DW-1]   ? DW'(-den_reg)   : DW'(den_reg);
    assign mag_b_next = num_b_reg[DW-1] ? DW'(-num_b_reg) : DW'(num_b_reg);
    assign mag_c_next = num_c_reg[DW-1] ? DW'(-num_c_reg) : DW'(num_c_reg);

    always_ff @(posedge clk) begin
        if (load[ST_S4]) begin
            dmag_reg[0]  <= dmag_next;
            rem_b_reg[0] <= '0;
            rem_c_reg[0] <= '0;
            dvd_b_reg[0] <= {mag_b_next, {WEIGHT_FRAC_BITS{1'b0}}};
            dvd_c_reg[0] <= {mag_c_next, {WEIGHT_FRAC_BITS{1'b0}}};
            sgn_b_reg[0] <= num_b_reg[DW-1] ^ den_reg[DW-1];
            sgn_c_reg[0] <= num_c_reg[DW-1] ^ den_reg[DW-1];
            degen_reg[0] <= (den_reg == '0);
        end
    end

    for (genvar k = 0; k < NQ; k++) begin : g_div
        logic [DW:0]   trial_b, trial_c;
        logic [DW+1:0] diff_b, diff_c;
        logic [DW-1:0] rem_b_next, rem_c_next;
        logic [NW-1:0] dvd_b_next, dvd_c_next;

        assign trial_b = {rem_b_reg[k], dvd_b_reg[k][NW-1]};
        assign trial_c = {rem_c_reg[k], dvd_c_reg[k][NW-1]};
        assign diff_b  = {1'b0, trial_b} - {2'b00, dmag_reg[k]};
        assign diff_c  = {1'b0, trial_c} - {2'b00, dmag_reg[k]};

        // No borrow means trial >= divisor: keep the difference, quotient bit 1.
        assign rem_b_next = diff_b[DW+1] ? trial_b[DW-1:0] : diff_b[DW-1:0];
        assign rem_c_next = diff_c[DW+1] ? trial_c[DW-1:0] : diff_c[DW-1:0];
        assign dvd_b_next = {dvd_b_reg[k][NW-2:0], !diff_b[DW+1]};
        assign dvd_c_next = {dvd_c_reg[k][NW-2:0], !diff_c[DW+1]};

        always_ff @(posedge clk) begin
            if (load[ST_S4+1+k]) begin
                dmag_reg[k+1]  <= dmag_reg[k];
                rem_b_reg[k+1] <= rem_b_next;
                rem_c_reg[k+1] <= rem_c_next;
                dvd_b_reg[k+1] <= dvd_b_next;
                dvd_c_reg[k+1] <= dvd_c_next;
                sgn_b_reg[k+1] <= sgn_b_reg[k];
                sgn_c_reg[k+1] <= sgn_c_reg[k];
                degen_reg[k+1] <= degen_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------------
    // S5: signed quotients
    // ------------------------------------------------------------------------
    logic signed [NW:0] qb_reg, qc_reg, qb_next, qc_next;
    logic               s5_degen_reg;

    assign qb_next = sgn_b_reg[NQ] ? -{1'b0, dvd_b_reg[NQ]} : {1'b0, dvd_b_reg[NQ]};
    assign qc_next = sgn_c_reg[NQ] ? -{1'b0, dvd_c_reg[NQ]} : {1'b0, dvd_c_reg[NQ]};

    always_ff @(posedge clk) begin
        if (load[ST_S5]) begin
            qb_reg       <= qb_next;
            qc_reg       <= qc_next;
            s5_degen_reg <= degen_reg[NQ];
        end
    end

    // ------------------------------------------------------------------------
    // S6: weight a from the unclipped b and c, clip b and c
    // ------------------------------------------------------------------------
    logic signed [XW-1:0]   qb_x, qc_x, one_x;
    logic signed [XW-1:0]   qa_reg, qa_next;
    logic [WEIGHT_WIDTH-1:0] wb_reg, wc_reg, wb_next, wc_next;
    logic                   sat_bc_reg, sat_bc_next;
    logic                   s6_degen_reg;
    logic                   fit_b, fit_c;

    assign qb_x  = {{(XW-NW-1){qb_reg[NW]}}, qb_reg};
    assign qc_x  = {{(XW-NW-1){qc_reg[NW]}}, qc_reg};
    assign one_x = {{(XW-1){1'b0}}, 1'b1} << WEIGHT_FRAC_BITS;

    assign qa_next = one_x - qb_x - qc_x;

    // Fits in 32 bits when everything from bit 31 up is a copy of the sign.
    assign fit_b = (&qb_x[XW-1:WEIGHT_WIDTH-1]) || !(|qb_x[XW-1:WEIGHT_WIDTH-1]);
    assign fit_c = (&qc_x[XW-1:WEIGHT_WIDTH-1]) || !(|qc_x[XW-1:WEIGHT_WIDTH-1]);

    assign wb_next = fit_b ? qb_x[WEIGHT_WIDTH-1:0] : (qb_x[XW-1] ? WEIGHT_MIN : WEIGHT_MAX);
    assign wc_next = fit_c ? qc_x[WEIGHT_WIDTH-1:0] : (qc_x[XW-1] ? WEIGHT_MIN : WEIGHT_MAX);
    assign sat_bc_next = !fit_b || !fit_c;

    always_ff @(posedge clk) begin
        if (load[ST_S6]) begin
            qa_reg       <= qa_next;
            wb_reg       <= wb_next;
            wc_reg       <= wc_next;
            sat_bc_reg   <= sat_bc_next;
            s6_degen_reg <= s5_degen_reg;
        end
    end

    // ------------------------------------------------------------------------
    // S7: clip a, zero everything on a degenerate triangle
    // ------------------------------------------------------------------------
    logic                    fit_a;
    logic [WEIGHT_WIDTH-1:0] wa_clip;
    logic [WEIGHT_WIDTH-1:0] wa_reg, wb_out_reg, wc_out_reg;
    logic [WEIGHT_WIDTH-1:0] wa_next, wb_out_next, wc_out_next;
    logic                    degen_out_reg, sat_out_reg, sat_out_next;

    assign fit_a   = (&qa_reg[XW-1:WEIGHT_WIDTH-1]) || !(|qa_reg[XW-1:WEIGHT_WIDTH-1]);
    assign wa_clip = fit_a ? qa_reg[WEIGHT_WIDTH-1:0]
                           : (qa_reg[XW-1] ? WEIGHT_MIN : WEIGHT_MAX);

    assign wa_next      = s6_degen_reg ? '0 : wa_clip;
    assign wb_out_next  = s6_degen_reg ? '0 : wb_reg;
    assign wc_out_next  = s6_degen_reg ? '0 : wc_reg;
    assign sat_out_next = !s6_degen_reg && (sat_bc_reg || !fit_a);

    always_ff @(posedge clk) begin
        if (load[ST_S7]) begin
            wa_reg        <= wa_next;
            wb_out_reg    <= wb_out_next;
            wc_out_reg    <= wc_out_next;
            sat_out_reg   <= sat_out_next;
            degen_out_reg <= s6_degen_reg;
        end
    end

    assign weight_a   = wa_reg;
    assign weight_b   = wb_out_reg;
    assign weight_c   = wc_out_reg;
    assign degenerate = degen_out_reg;
    assign saturated  = sat_out_reg;

endmodule
